### rtl/core/wws_pkg.sv
// Shared types, codes and constants of the weekly window scheduler.
`default_nettype none
package wws_pkg;

	localparam int MAX_SLOTS_DEF = 8;
	localparam int DAYS_PER_WEEK = 7;
	localparam int WALK_DAYS     = DAYS_PER_WEEK * 2;
	localparam int SECS_PER_DAY  = 60 * 60 * 24;

	localparam int TOD_W  = 17;
	localparam int NOW_W  = 20;
	localparam int TIME_W = 21;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_COUNT = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_QUERY = 2'd3
	} cmd_code_t;

	typedef enum logic [1:0] {
		ST_NONE    = 2'd0,
		ST_ENABLE  = 2'd1,
		ST_DISABLE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DAY,
		S_END,
		S_START,
		S_LAST,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]       command;
		logic [2:0]       day;
		logic [2:0]       slot;
		logic [TOD_W-1:0] start_sec;
		logic [TOD_W-1:0] end_sec;
		logic [3:0]       window_count;
		logic [NOW_W-1:0] now_sec;
	} cmd_item_t;

	typedef struct packed {
		logic              next_found;
		logic [TIME_W-1:0] next_time;
		logic              next_is_start;
		logic              enabled;
		logic              status_changed;
		logic [TIME_W-1:0] delay_sec;
	} rsp_item_t;

	// Control toward the point evaluation unit.
	typedef struct packed {
		logic              clear;
		logic              strobe;
		logic              is_start;
		logic [TIME_W-1:0] t;
		logic [NOW_W-1:0]  now;
	} walk_op_t;

	// What the point evaluation unit has found so far.
	typedef struct packed {
		logic              found;
		logic              next_s;
		logic [TIME_W-1:0] next_t;
	} walk_res_t;

endpackage
`default_nettype wire

### rtl/core/weekly_window_scheduler.sv
// Top level of the weekly window scheduler: command decode, walk sequencer, result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  cmd     | in        | cmd_valid, cmd_stall | wws_pkg::cmd_item_t (command)
//  rsp     | out       | rsp_valid, rsp_stall | wws_pkg::rsp_item_t (result)
//
// Write, count and clear commands yield an all-zero result, registered on acceptance.
// A query walks two weeks through the point evaluation unit: a day step for each day,
// an end and a start step for each stored window, then a last and a done step.
// The window table RAM read port fetches each next window during the day or start step.
// arst_n clears the day counts, the stored status and all control state.
// Held results stall writes, counts, clears and a query's finish; commands wait for a query.
`default_nettype none
module weekly_window_scheduler #(
	parameter int MAX_SLOTS = wws_pkg::MAX_SLOTS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	output logic                     cmd_stall,
	input  wire wws_pkg::cmd_item_t  cmd,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output wws_pkg::rsp_item_t       rsp
);

	localparam int DEPTH  = wws_pkg::DAYS_PER_WEEK * MAX_SLOTS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
	localparam int TOD_W  = wws_pkg::TOD_W;
	localparam int TIME_W = wws_pkg::TIME_W;

	wws_pkg::state_t  state_q, state_d;
	wws_pkg::status_t status_q, new_status;

	logic [CNT_W-1:0]  cnt_q [wws_pkg::DAYS_PER_WEEK];
	logic [3:0]        i_q;
	logic [2:0]        d_q;
	logic [CNT_W-1:0]  j_q;
	logic [TIME_W-1:0] base_q;
	logic [TIME_W-1:0] end_t_q;
	logic              end_valid_q;
	logic [wws_pkg::NOW_W-1:0] now_q;

	wws_pkg::rsp_item_t rsp_q, done_rsp;
	logic               rsp_valid_q;

	logic              cmd_acc, out_free, is_query, last_day, more;
	logic [CNT_W-1:0]  day_cnt;
	logic [CNT_W-1:0]  rd_slot;
	logic              rd_en, wr_en;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic [2*TOD_W-1:0] wr_data, rd_data;
	logic [TOD_W-1:0]  sat_start, sat_end;
	logic [TIME_W-1:0] s_pt, e_pt, now_ext, delay;
	logic              done_fire;

	wws_pkg::walk_op_t  op;
	wws_pkg::walk_res_t res;

	// handshake
	assign is_query  = (cmd.command == wws_pkg::CMD_QUERY);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = (state_q != wws_pkg::S_IDLE) || (!out_free && !is_query);
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// table writes
	assign sat_start = (cmd.start_sec > TOD_W'(wws_pkg::SECS_PER_DAY)) ?
		TOD_W'(wws_pkg::SECS_PER_DAY) : cmd.start_sec;
	assign sat_end   = (cmd.end_sec > TOD_W'(wws_pkg::SECS_PER_DAY)) ?
		TOD_W'(wws_pkg::SECS_PER_DAY) : cmd.end_sec;
	assign wr_en   = cmd_acc && (cmd.command == wws_pkg::CMD_WRITE)
		&& (32'(cmd.day) < wws_pkg::DAYS_PER_WEEK) && (32'(cmd.slot) < MAX_SLOTS);
	assign wr_addr = ADDR_W'(cmd.day) * ADDR_W'(MAX_SLOTS) + ADDR_W'(cmd.slot);
	assign wr_data = {sat_start, sat_end};

	wws_ram #(
		.WIDTH (2 * TOD_W),
		.DEPTH (DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	wws_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.res    (res)
	);

	// walk position
	assign day_cnt  = cnt_q[d_q];
	assign last_day = (i_q == 4'(wws_pkg::WALK_DAYS - 1));
	assign more     = ({1'b0, j_q} + 1'b1) < {1'b0, day_cnt};
	assign rd_slot  = (state_q == wws_pkg::S_START) ? j_q + 1'b1 : '0;
	assign rd_addr  = ADDR_W'(d_q) * ADDR_W'(MAX_SLOTS) + ADDR_W'(rd_slot);
	assign s_pt     = base_q + TIME_W'(rd_data[2*TOD_W-1:TOD_W]);
	assign e_pt     = base_q + TIME_W'(rd_data[TOD_W-1:0]);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wws_pkg::S_IDLE: begin
				if (cmd_acc && is_query) begin
					state_d = wws_pkg::S_DAY;
				end
			end
			wws_pkg::S_DAY: begin
				if (day_cnt != '0) begin
					state_d = wws_pkg::S_END;
				end else if (last_day) begin
					state_d = wws_pkg::S_LAST;
				end
			end
			wws_pkg::S_END: state_d = wws_pkg::S_START;
			wws_pkg::S_START: begin
				if (more) begin
					state_d = wws_pkg::S_END;
				end else if (last_day) begin
					state_d = wws_pkg::S_LAST;
				end else begin
					state_d = wws_pkg::S_DAY;
				end
			end
			wws_pkg::S_LAST: state_d = wws_pkg::S_DONE;
			wws_pkg::S_DONE: begin
				if (out_free) begin
					state_d = wws_pkg::S_IDLE;
				end
			end
			default: state_d = wws_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		rd_en       = 1'b0;
		done_fire   = 1'b0;
		op.clear    = 1'b0;
		op.strobe   = 1'b0;
		op.is_start = 1'b0;
		op.t        = end_t_q;
		op.now      = now_q;
		unique case (state_q)
			wws_pkg::S_IDLE: op.clear = cmd_acc && is_query;
			wws_pkg::S_DAY: rd_en = (day_cnt != '0);
			wws_pkg::S_END: begin
				// close the previous window unless this one starts at its end
				op.strobe = end_valid_q && (end_t_q != s_pt);
			end
			wws_pkg::S_START: begin
				rd_en       = more;
				op.strobe   = !end_valid_q || (end_t_q != s_pt);
				op.is_start = 1'b1;
				op.t        = s_pt;
			end
			wws_pkg::S_LAST: op.strobe = end_valid_q;
			wws_pkg::S_DONE: done_fire = out_free;
			default: ;
		endcase
	end

	// result of a finished walk
	assign now_ext    = TIME_W'(now_q);
	assign delay      = (res.next_t > now_ext) ? res.next_t - now_ext : TIME_W'(1);
	assign new_status = (res.found && !res.next_s) ? wws_pkg::ST_ENABLE : wws_pkg::ST_DISABLE;

	always_comb begin
		done_rsp                = '0;
		done_rsp.enabled        = (new_status == wws_pkg::ST_ENABLE);
		done_rsp.status_changed = (new_status != status_q);
		if (res.found) begin
			done_rsp.next_found    = 1'b1;
			done_rsp.next_time     = res.next_t;
			done_rsp.next_is_start = res.next_s;
			done_rsp.delay_sec     = delay;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wws_pkg::S_IDLE;
			status_q    <= wws_pkg::ST_NONE;
			rsp_valid_q <= 1'b0;
			end_valid_q <= 1'b0;
			i_q         <= '0;
			d_q         <= '0;
			j_q         <= '0;
			for (int k = 0; k < wws_pkg::DAYS_PER_WEEK; k++) begin
				cnt_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;

			if (cmd_acc && (cmd.command == wws_pkg::CMD_COUNT)
				&& (32'(cmd.day) < wws_pkg::DAYS_PER_WEEK)) begin
				cnt_q[cmd.day] <= (32'(cmd.window_count) > MAX_SLOTS) ?
					CNT_W'(MAX_SLOTS) : CNT_W'(cmd.window_count);
			end

			if (cmd_acc && (cmd.command == wws_pkg::CMD_CLEAR)) begin
				status_q <= wws_pkg::ST_NONE;
			end else if (done_fire) begin
				status_q <= new_status;
			end

			if ((cmd_acc && !is_query) || done_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				wws_pkg::S_IDLE: begin
					if (cmd_acc && is_query) begin
						i_q         <= '0;
						d_q         <= '0;
						end_valid_q <= 1'b0;
					end
				end
				wws_pkg::S_DAY: begin
					if (day_cnt != '0) begin
						j_q <= '0;
					end else begin
						i_q <= i_q + 1'b1;
						d_q <= (d_q == 3'(wws_pkg::DAYS_PER_WEEK - 1)) ? '0 : d_q + 1'b1;
					end
				end
				wws_pkg::S_START: begin
					end_valid_q <= 1'b1;
					if (more) begin
						j_q <= j_q + 1'b1;
					end else begin
						i_q <= i_q + 1'b1;
						d_q <= (d_q == 3'(wws_pkg::DAYS_PER_WEEK - 1)) ? '0 : d_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_acc && is_query) begin
			now_q  <= cmd.now_sec;
			base_q <= '0;
		end
		if (((state_q == wws_pkg::S_DAY) && (day_cnt == '0))
			|| ((state_q == wws_pkg::S_START) && !more)) begin
			base_q <= base_q + TIME_W'(wws_pkg::SECS_PER_DAY);
		end
		if (state_q == wws_pkg::S_START) begin
			end_t_q <= e_pt;
		end
		if (cmd_acc && !is_query) begin
			rsp_q <= '0;
		end else if (done_fire) begin
			rsp_q <= done_rsp;
		end
	end

endmodule
`default_nettype wire

### rtl/core/wws_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

### rtl/core/wws_walk.sv
// Point evaluation unit: checks one switch point per strobe against the query time.
`default_nettype none
module wws_walk (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire wws_pkg::walk_op_t  op,
	output wws_pkg::walk_res_t      res
);

	logic                       have_prev_q;
	logic [wws_pkg::TIME_W-1:0] prev_t_q;
	logic                       found_q;
	logic                       next_s_q;
	logic [wws_pkg::TIME_W-1:0] next_t_q;
	logic [wws_pkg::TIME_W-1:0] now_ext;
	logic                       hit;

	assign now_ext = wws_pkg::TIME_W'(op.now);
	assign hit     = have_prev_q && (now_ext >= prev_t_q) && (now_ext < op.t);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			found_q     <= 1'b0;
		end else if (op.clear) begin
			have_prev_q <= 1'b0;
			found_q     <= 1'b0;
		end else if (op.strobe) begin
			have_prev_q <= 1'b1;
			// later bracketing pairs override earlier ones
			if (hit) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op.strobe) begin
			prev_t_q <= op.t;
			if (hit) begin
				next_t_q <= op.t;
				next_s_q <= op.is_start;
			end
		end
	end

	assign res.found  = found_q;
	assign res.next_s = next_s_q;
	assign res.next_t = next_t_q;

endmodule
`default_nettype wire

### tb/weekly_window_scheduler_test.sv
// Self-checking testbench for the weekly window scheduler: directed table, then random traffic.
module weekly_window_scheduler_test;
	import wws_pkg::*;

	localparam int MAX_SLOTS       = MAX_SLOTS_DEF;
	localparam int TOD_MAX         = (1 << TOD_W) - 1;
	localparam int NOW_MAX         = (1 << NOW_W) - 1;
	localparam int WEEK_SECS       = DAYS_PER_WEEK * SECS_PER_DAY;
	localparam int COUNT_MAX       = 15;
	localparam int MONDAY          = 0;
	localparam int TUESDAY         = 1;
	localparam int BAD_DAY         = 7;
	localparam int RANDOM_ITEMS    = 1275;
	localparam int CALM_TAIL       = 150;
	localparam int LONG_HOLD       = 3000;
	localparam int LONG_HOLD_AFTER = 400;
	localparam int DRAIN_CYCLES    = 400;
	localparam int LIMIT_CYCLES    = 2000000;
	localparam bit BY_MODEL        = 1'b0;
	localparam bit TYPED           = 1'b1;

	localparam rsp_item_t NO_RSP  = '0;
	localparam rsp_item_t OFF_NEW = '{status_changed: 1'b1, default: '0};

	typedef struct packed {
		cmd_item_t item;
		logic      typed;
		rsp_item_t exp;
	} cmd_plan_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	cmd_item_t cmd = '0;
	logic      rsp_stall = 1'b0;
	logic      cmd_stall;
	logic      rsp_valid;
	rsp_item_t rsp;

	cmd_plan_t cmd_plan [$];
	cmd_plan_t cur_plan = '0;
	rsp_item_t owed_rsp [$];
	int        plan_total = 0;
	int        results_seen = 0;
	int        fail_count = 0;
	int        cycle_count = 0;
	bit        calm = 1'b0;

	// shadow of the table as the command stream builds it, used to aim queries
	bit [MAX_SLOTS-1:0] gen_written [DAYS_PER_WEEK] = '{default: '0};
	int                 gen_start [DAYS_PER_WEEK][MAX_SLOTS];
	int                 gen_end [DAYS_PER_WEEK][MAX_SLOTS];
	int                 gen_count [DAYS_PER_WEEK] = '{default: 0};

	// predictor state
	logic [TOD_W-1:0] tbl_start [DAYS_PER_WEEK][MAX_SLOTS];
	logic [TOD_W-1:0] tbl_end [DAYS_PER_WEEK][MAX_SLOTS];
	logic [3:0]       tbl_count [DAYS_PER_WEEK] = '{default: '0};
	status_t          tbl_status = ST_NONE;

	weekly_window_scheduler #(.MAX_SLOTS(MAX_SLOTS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [TOD_W-1:0] sat_tod(input logic [TOD_W-1:0] v);
		return (v > SECS_PER_DAY) ? TOD_W'(SECS_PER_DAY) : v;
	endfunction

	// Largest count that keeps every covered slot written.
	function automatic int count_cap(input int d);
		int p;
		p = 0;
		while (p < MAX_SLOTS && gen_written[d][p])
			p++;
		return (p == MAX_SLOTS) ? COUNT_MAX : p;
	endfunction

	// Aim most queries at a switch point, up to two seconds either side of it or on it.
	function automatic int pick_now();
		int i, d, j, t, now;
		case ($urandom_range(0, 9))
		0, 1, 2, 3, 4, 5: begin
			i = $urandom_range(0, WALK_DAYS - 1);
			d = i % DAYS_PER_WEEK;
			if (gen_count[d] == 0) begin
				now = $urandom_range(0, WEEK_SECS - 1);
			end else begin
				j = $urandom_range(0, gen_count[d] - 1);
				t = ($urandom_range(0, 1) != 0) ? gen_start[d][j] : gen_end[d][j];
				t = i * SECS_PER_DAY + t + int'($urandom_range(0, 4)) - 2;
				now = (t < 0) ? 0 : (t > NOW_MAX) ? NOW_MAX : t;
			end
		end
		6, 7: now = $urandom_range(0, WEEK_SECS - 1);
		8: now = $urandom_range(0, NOW_MAX);
		default: begin
			case ($urandom_range(0, 3))
			0: now = 0;
			1: now = WEEK_SECS - 1;
			2: now = WEEK_SECS;
			default: now = NOW_MAX;
			endcase
		end
		endcase
		return now;
	endfunction

	// Queue one command; fields the command does not use stay random.
	task automatic plan_cmd(input cmd_code_t op, input int d, input int s, input int st,
			input int en, input int cnt, input int now, input bit typed, input rsp_item_t exp);
		logic [95:0] raw;
		cmd_item_t   it;
		cmd_plan_t   p;
		raw = {$urandom, $urandom, $urandom};
		it = raw[$bits(cmd_item_t)-1:0];
		it.command = op;
		case (op)
		CMD_WRITE: begin
			it.day = 3'(d);
			it.slot = 3'(s);
			it.start_sec = TOD_W'(st);
			it.end_sec = TOD_W'(en);
		end
		CMD_COUNT: begin
			it.day = 3'(d);
			it.window_count = 4'(cnt);
		end
		CMD_QUERY: it.now_sec = NOW_W'(now);
		default: ;
		endcase
		if (it.day < DAYS_PER_WEEK) begin
			if (op == CMD_WRITE && int'(it.slot) < MAX_SLOTS) begin
				gen_written[it.day][it.slot] = 1'b1;
				gen_start[it.day][it.slot] = sat_tod(it.start_sec);
				gen_end[it.day][it.slot] = sat_tod(it.end_sec);
			end else if (op == CMD_COUNT) begin
				gen_count[it.day] = (it.window_count > MAX_SLOTS) ? MAX_SLOTS : it.window_count;
			end
		end
		if (!(it.day >= DAYS_PER_WEEK && (op == CMD_WRITE || op == CMD_COUNT)))
			plan_total++;
		p.item = it;
		p.typed = typed;
		p.exp = exp;
		cmd_plan.push_back(p);
	endtask

	// Apply one command to the predictor and work out the result it owes.
	task automatic compute_switch(input cmd_item_t c, output rsp_item_t r);
		int unsigned pt_t [$];
		bit          pt_s [$];
		int unsigned base, s, end_t, now, next_t;
		bit          end_valid, found, next_s;
		int          d;
		status_t     fresh;
		r = '0;
		case (c.command)
		CMD_WRITE: begin
			if (c.day < DAYS_PER_WEEK && int'(c.slot) < MAX_SLOTS) begin
				tbl_start[c.day][c.slot] = sat_tod(c.start_sec);
				tbl_end[c.day][c.slot] = sat_tod(c.end_sec);
			end
		end
		CMD_COUNT: begin
			if (c.day < DAYS_PER_WEEK)
				tbl_count[c.day] = (c.window_count > MAX_SLOTS) ? 4'(MAX_SLOTS) : c.window_count;
		end
		CMD_CLEAR: tbl_status = ST_NONE;
		default: begin
			now = c.now_sec;
			end_valid = 1'b0;
			end_t = 0;
			// walk two weeks; a start equal to the open end merges into that window
			for (int i = 0; i < WALK_DAYS; i++) begin
				d = i % DAYS_PER_WEEK;
				base = i * SECS_PER_DAY;
				for (int j = 0; j < int'(tbl_count[d]); j++) begin
					s = base + tbl_start[d][j];
					if (!end_valid) begin
						pt_t.push_back(s);
						pt_s.push_back(1'b1);
					end else if (end_t != s) begin
						pt_t.push_back(end_t);
						pt_s.push_back(1'b0);
						pt_t.push_back(s);
						pt_s.push_back(1'b1);
					end
					end_t = base + tbl_end[d][j];
					end_valid = 1'b1;
				end
			end
			if (end_valid) begin
				pt_t.push_back(end_t);
				pt_s.push_back(1'b0);
			end
			found = 1'b0;
			next_t = 0;
			next_s = 1'b0;
			// last bracketing pair wins
			for (int k = 1; k < pt_t.size(); k++) begin
				if (now >= pt_t[k-1] && now < pt_t[k]) begin
					found = 1'b1;
					next_t = pt_t[k];
					next_s = pt_s[k];
				end
			end
			fresh = (!found || next_s) ? ST_DISABLE : ST_ENABLE;
			r.status_changed = (fresh != tbl_status);
			tbl_status = fresh;
			r.enabled = (fresh == ST_ENABLE);
			if (found) begin
				r.next_found = 1'b1;
				r.next_time = TIME_W'(next_t);
				r.next_is_start = next_s;
				r.delay_sec = TIME_W'((next_t > now) ? next_t - now : 1);
			end
		end
		endcase
	endtask

	function automatic string rsp_text(input rsp_item_t r);
		return $sformatf("found=%0b time=%0d start=%0b en=%0b chg=%0b delay=%0d",
			r.next_found, r.next_time, r.next_is_start, r.enabled, r.status_changed,
			r.delay_sec);
	endfunction

	task automatic log_failure(input string what, input rsp_item_t want, input rsp_item_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("cycle %0d: %s\n  expected %s\n  actual   %s", cycle_count, what,
				rsp_text(want), rsp_text(got));
	endtask

	task automatic check_result(input rsp_item_t got);
		rsp_item_t want;
		bit        bad;
		results_seen++;
		if (owed_rsp.size() == 0) begin
			log_failure("result with no transaction pending", NO_RSP, got);
			return;
		end
		want = owed_rsp.pop_front();
		bad = got.next_found !== want.next_found || got.next_time !== want.next_time ||
			got.next_is_start !== want.next_is_start || got.enabled !== want.enabled ||
			got.status_changed !== want.status_changed || got.delay_sec !== want.delay_sec;
		if (bad)
			log_failure("result mismatch", want, got);
	endtask

	// Predict on every accepted command, check every accepted result.
	always @(posedge clk) begin
		rsp_item_t model_rsp;
		if (arst_n) begin
			if (cmd_valid && !cmd_stall) begin
				compute_switch(cmd, model_rsp);
				owed_rsp.push_back(cur_plan.typed ? cur_plan.exp : model_rsp);
			end
			if (rsp_valid && !rsp_stall)
				check_result(rsp);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Result side: random stall bursts, plus one long hold to back the block up.
	initial begin
		bit long_done;
		long_done = 1'b0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			@(posedge clk);
			if (!long_done && results_seen >= LONG_HOLD_AFTER) begin
				long_done = 1'b1;
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				rsp_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin
		int dir_rows, pick, d, n, t, st, en, c, nd;

		// empty table, then status clear
		plan_cmd(CMD_QUERY, 0, 0, 0, 0, 0, 0, TYPED, OFF_NEW);
		plan_cmd(CMD_QUERY, 0, 0, 0, 0, 0, NOW_MAX, TYPED, NO_RSP);
		plan_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, TYPED, NO_RSP);
		plan_cmd(CMD_QUERY, 0, 0, 0, 0, 0, WEEK_SECS - 1, TYPED, OFF_NEW);
		// Monday: two windows that merge, then one saturated on both ends
		plan_cmd(CMD_WRITE, MONDAY, 0, 0, 3600, 0, 0, TYPED, NO_RSP);
		plan_cmd(CMD_WRITE, MONDAY, 1, 3600, 7200, 0, 0, TYPED, NO_RSP);
		plan_cmd(CMD_WRITE, MONDAY, 2, TOD_MAX, 100000, 0, 0, TYPED, NO_RSP);
		plan_cmd(CMD_WRITE, BAD_DAY, 5, 10, 20, 0, 0, TYPED, NO_RSP);
		plan_cmd(CMD_COUNT, BAD_DAY, 0, 0, 0, COUNT_MAX, 0, TYPED, NO_RSP);
		plan_cmd(CMD_COUNT, MONDAY, 0, 0, 0, 3, 0, TYPED, NO_RSP);
		plan_cmd(CMD_QUERY, 0, 0, 0, 0, 0, 0, BY_MODEL, NO_RSP);
		plan_cmd(CMD_QUERY, 0, 0, 0, 0, 0, 7199, BY_MODEL, NO_RSP);
		plan_cmd(CMD_QUERY, 0, 0, 0, 0, 0, 7200, BY_MODEL, NO_RSP);
		plan_cmd(CMD_QUERY, 0, 0, 0, 0, 0, SECS_PER_DAY, BY_MODEL, NO_RSP);
		plan_cmd(CMD_QUERY, 0, 0, 0, 0, 0, WEEK_SECS - 1, BY_MODEL, NO_RSP);
		plan_cmd(CMD_QUERY, 0, 0, 0, 0, 0, WEEK_SECS, BY_MODEL, NO_RSP);
		plan_cmd(CMD_QUERY, 0, 0, 0, 0, 0, NOW_MAX, BY_MODEL, NO_RSP);
		// Tuesday: window with end before start
		plan_cmd(CMD_WRITE, TUESDAY, 0, 50000, 40000, 0, 0, TYPED, NO_RSP);
		plan_cmd(CMD_COUNT, TUESDAY, 0, 0, 0, 1, 0, TYPED, NO_RSP);
		plan_cmd(CMD_COUNT, MONDAY, 0, 0, 0, 0, 0, TYPED, NO_RSP);
		plan_cmd(CMD_QUERY, 0, 0, 0, 0, 0, 130000, BY_MODEL, NO_RSP);
		plan_cmd(CMD_QUERY, 0, 0, 0, 0, 0, 45000, BY_MODEL, NO_RSP);
		plan_cmd(CMD_COUNT, TUESDAY, 0, 0, 0, 0, 0, TYPED, NO_RSP);
		plan_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, TYPED, NO_RSP);
		plan_cmd(CMD_QUERY, 0, 0, 0, 0, 0, 12345, TYPED, OFF_NEW);
		dir_rows = cmd_plan.size();

		while (plan_total < dir_rows + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				// program one day with mostly ordered windows, then query it
				d = $urandom_range(0, DAYS_PER_WEEK - 1);
				n = ($urandom_range(0, 2) == 0) ? MAX_SLOTS : $urandom_range(1, MAX_SLOTS);
				t = $urandom_range(0, 30000);
				for (int j = 0; j < n; j++) begin
					if (j == 0 || $urandom_range(0, 2) != 0)
						t = t + $urandom_range(0, 6000);
					st = t;
					en = st + $urandom_range(1, 9000);
					if ($urandom_range(0, 11) == 0) begin
						st = en;
						en = t;
					end
					if ($urandom_range(0, 15) == 0)
						en = $urandom_range(SECS_PER_DAY, TOD_MAX);
					st = (st > TOD_MAX) ? TOD_MAX : st;
					en = (en > TOD_MAX) ? TOD_MAX : en;
					plan_cmd(CMD_WRITE, d, j, st, en, 0, 0, BY_MODEL, NO_RSP);
					t = en;
				end
				c = ($urandom_range(0, 5) == 0) ? $urandom_range(0, count_cap(d)) : n;
				plan_cmd(CMD_COUNT, d, 0, 0, 0, c, 0, BY_MODEL, NO_RSP);
				if ($urandom_range(0, 4) == 0)
					plan_cmd(CMD_COUNT, $urandom_range(0, DAYS_PER_WEEK - 1), 0, 0, 0, 0, 0,
						BY_MODEL, NO_RSP);
				repeat ($urandom_range(1, 4))
					plan_cmd(CMD_QUERY, 0, 0, 0, 0, 0, pick_now(), BY_MODEL, NO_RSP);
			end else if (pick < 80) begin
				repeat ($urandom_range(1, 5))
					plan_cmd(CMD_QUERY, 0, 0, 0, 0, 0, pick_now(), BY_MODEL, NO_RSP);
			end else if (pick < 90) begin
				plan_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, BY_MODEL, NO_RSP);
				plan_cmd(CMD_QUERY, 0, 0, 0, 0, 0, pick_now(), BY_MODEL, NO_RSP);
			end else begin
				repeat ($urandom_range(1, 3)) begin
					nd = $urandom_range(0, 7);
					c = (nd < DAYS_PER_WEEK) ? $urandom_range(0, count_cap(nd)) :
						$urandom_range(0, COUNT_MAX);
					plan_cmd(cmd_code_t'($urandom_range(0, 3)), nd, $urandom_range(0, 7),
						$urandom_range(0, TOD_MAX), $urandom_range(0, TOD_MAX), c,
						$urandom_range(0, NOW_MAX), BY_MODEL, NO_RSP);
				end
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < cmd_plan.size(); k++) begin
			calm = (k >= cmd_plan.size() - CALM_TAIL) || ((k / 128) % 4 == 3);
			if (k == dir_rows || k == cmd_plan.size() / 2) begin
				// drain the block completely before going on
				cmd_valid <= 1'b0;
				do @(posedge clk); while (owed_rsp.size() != 0);
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				cmd_valid <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			cmd_valid <= 1'b1;
			cmd <= cmd_plan[k].item;
			cur_plan <= cmd_plan[k];
			// hold the transaction until it is taken
			do @(posedge clk); while (cmd_stall);
		end
		cmd_valid <= 1'b0;
		do @(posedge clk); while (owed_rsp.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (owed_rsp.size() != 0)
			log_failure("result never arrived", owed_rsp[0], NO_RSP);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### filelist.f
rtl/core/wws_pkg.sv
rtl/core/wws_ram.sv
rtl/core/wws_walk.sv
rtl/core/weekly_window_scheduler.sv
tb/weekly_window_scheduler_test.sv
